### sv/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside of reset.
`define AST_HOLDS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Property that is checked during reset as well.
`define AST_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### sv/pdcd_pkg.sv
package pdcd_pkg;

    localparam int PIX_BITS      = 32;
    localparam int IMG_W_BITS    = 13;
    localparam int MODE_BITS     = 2;
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 13;
    localparam int MAX_WIDTH_DEF = 4096;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CHANNEL_MODE = 4'd1;

    // Channel mode codes; any other code behaves as four channels.
    localparam logic [MODE_BITS-1:0] MODE_ONE_CHAN   = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_THREE_CHAN = 2'd1;

    localparam logic [IMG_W_BITS-1:0] IMG_W_RESET = 13'd1;
    localparam logic [MODE_BITS-1:0]  MODE_RESET  = MODE_THREE_CHAN;

    // One classified pixel, as the front end hands it on.
    typedef struct packed {
        logic [PIX_BITS-1:0] pix;
        logic                first_row;
        logic                col_zero;
        logic                last;
    } t_item;

    // Queue entry: the pixel together with the stored pixel above it.
    typedef struct packed {
        t_item               item;
        logic [PIX_BITS-1:0] above;
    } t_qent;

endpackage

### sv/pdcd_front.sv
module pdcd_front #(
    parameter int MAX_WIDTH = pdcd_pkg::MAX_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [pdcd_pkg::PIX_BITS-1:0]       i_pix,
    input  logic                                i_sof,
    input  logic [pdcd_pkg::IMG_W_BITS-1:0]     i_image_width,
    output logic                                o_valid,
    output pdcd_pkg::t_qent                     o_ent,
    input  logic                                i_ready
);

    localparam int AW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CMPW = (AW + 1 > pdcd_pkg::IMG_W_BITS) ? AW + 1 : pdcd_pkg::IMG_W_BITS;
    localparam logic [pdcd_pkg::IMG_W_BITS-1:0] W_ONE = pdcd_pkg::IMG_W_BITS'(1);

    logic [pdcd_pkg::PIX_BITS-1:0] r_mem [MAX_WIDTH];
    logic [pdcd_pkg::PIX_BITS-1:0] r_above;
    logic                          r_valid;
    pdcd_pkg::t_item               r_item;
    logic [AW-1:0]                 r_col;
    logic                          r_first_row;

    logic            accept;
    logic [AW-1:0]   col;
    logic            first_row;
    logic [CMPW-1:0] col_p1;
    logic            last;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    // A new image restarts the column and the first-row state.
    always_comb begin
        col       = i_sof ? '0 : r_col;
        first_row = i_sof ? 1'b1 : r_first_row;
        col_p1    = CMPW'(col) + CMPW'(1);
        last      = (i_image_width <= W_ONE)
                 || (col_p1 >= CMPW'(i_image_width))
                 || (col == AW'(MAX_WIDTH - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_col       <= '0;
            r_first_row <= 1'b1;
        end else begin
            if (accept) begin
                r_valid     <= 1'b1;
                r_col       <= last ? '0 : col_p1[AW-1:0];
                r_first_row <= last ? 1'b0 : first_row;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.pix       <= i_pix;
            r_item.first_row <= first_row;
            r_item.col_zero  <= (col == '0);
            r_item.last      <= last;
        end
    end

    // Read-first line store: the old pixel above comes out while the
    // current pixel takes its place.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_above    <= r_mem[col];
            r_mem[col] <= i_pix;
        end
    end

    assign o_valid     = r_valid;
    assign o_ent.item  = r_item;
    assign o_ent.above = r_above;

endmodule

### sv/pdcd_queue.sv
module pdcd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  pdcd_pkg::t_qent i_ent,
    output logic            o_valid,
    output pdcd_pkg::t_qent o_ent,
    input  logic            i_ready
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    pdcd_pkg::t_qent r_mem [DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [CW-1:0]   r_cnt;

    logic push;
    logic pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_ent   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + PW'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_ent;
        end
    end

endmodule

### sv/pdcd_back.sv
module pdcd_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  pdcd_pkg::t_qent                i_ent,
    input  logic [pdcd_pkg::MODE_BITS-1:0] i_mode,
    output logic                           o_valid,
    output logic [pdcd_pkg::PIX_BITS-1:0]  o_res,
    output logic                           o_last,
    input  logic                           i_ready
);

    logic                          r_valid;
    logic [pdcd_pkg::PIX_BITS-1:0] r_res;
    logic                          r_last;
    logic [pdcd_pkg::PIX_BITS-1:0] r_pvd;

    logic                          accept;
    logic [pdcd_pkg::PIX_BITS-1:0] above;
    logic [pdcd_pkg::PIX_BITS-1:0] prev;
    logic [pdcd_pkg::PIX_BITS-1:0] vdiff;
    logic [pdcd_pkg::PIX_BITS-1:0] val;
    logic [pdcd_pkg::PIX_BITS-1:0] res;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        above = i_ent.item.first_row ? '0 : i_ent.above;
        prev  = i_ent.item.col_zero ? '0 : r_pvd;
        for (int k = 0; k < 4; k++) begin
            vdiff[8*k +: 8] = i_ent.item.pix[8*k +: 8] - above[8*k +: 8];
            val[8*k +: 8]   = vdiff[8*k +: 8] - prev[8*k +: 8];
        end
        case (i_mode)
            pdcd_pkg::MODE_ONE_CHAN: begin
                res = {24'd0, val[7:0]};
            end
            pdcd_pkg::MODE_THREE_CHAN: begin
                res = {8'd0, val[23:16] - val[15:8], val[15:8], val[7:0] - val[15:8]};
            end
            default: begin
                res = {val[31:24], val[23:16] - val[15:8], val[15:8],
                       val[7:0] - val[15:8]};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pvd   <= '0;
        end else begin
            if (accept) begin
                r_valid <= 1'b1;
                r_pvd   <= vdiff;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res  <= res;
            r_last <= i_ent.item.last;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
    assign o_last  = r_last;

endmodule

### sv/pixel_delta_color_decorrelator.sv
// Pixel delta color decorrelator. Pixels enter one per item in raster order,
// chan0 to chan3 in memory order in the input tdata and a start-of-image flag
// in tuser. Each channel has the same channel of the pixel above subtracted
// (nothing on the first row of an image), then the previous pixel's vertical
// difference in the row (zero at row start); in three and four channel modes
// channels 0 and 2 then have channel 1 subtracted, all modulo 256. Each input
// item gives exactly one result item, with tlast marking the last pixel of a
// row. The block takes one item per clock cycle when the output is drained;
// the rate is set by the single-port line store, which is read and written at
// the same address in the cycle an item enters. An item passes from the front
// end register, where the line store read is registered, through the
// two-entry queue into the output register. The line store holds MAX_WIDTH
// 32-bit words and is not cleared after reset; only rows after the first of
// an image use what it returns. Configuration must be written only while no
// item is in flight; the block itself does not enforce this.
module pixel_delta_color_decorrelator #(
    parameter int MAX_WIDTH = pdcd_pkg::MAX_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration write port.
    input  logic                                 i_cfg_we,
    input  logic [pdcd_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [pdcd_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    // Pixel input.
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [31:0]                          i_s_axis_tdata, // chan0, chan1, chan2, chan3
    input  logic [0:0]                           i_s_axis_tuser, // start_of_image
    // Result output.
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [31:0]                          o_m_axis_tdata, // res0, res1, res2, res3
    output logic                                 o_m_axis_tlast  // end_of_row
);

    logic [pdcd_pkg::IMG_W_BITS-1:0] r_image_width;
    logic [pdcd_pkg::MODE_BITS-1:0]  r_channel_mode;

    logic            front_ready;
    logic            front_valid;
    pdcd_pkg::t_qent front_ent;
    logic            queue_ready;
    logic            queue_valid;
    pdcd_pkg::t_qent queue_ent;
    logic            back_ready;

    // Configuration registers. Writes to an unknown index are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= pdcd_pkg::IMG_W_RESET;
            r_channel_mode <= pdcd_pkg::MODE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pdcd_pkg::CFG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg_data;
                end
                pdcd_pkg::CFG_CHANNEL_MODE: begin
                    r_channel_mode <= i_cfg_data[pdcd_pkg::MODE_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // No item is taken while reset is held.
    assign o_s_axis_tready = front_ready && i_rst_n;

    // The front end tracks the column and first-row state, classifies each
    // pixel and does the line store access.
    pdcd_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (front_ready),
        .i_pix         (i_s_axis_tdata),
        .i_sof         (i_s_axis_tuser[0]),
        .i_image_width (r_image_width),
        .o_valid       (front_valid),
        .o_ent         (front_ent),
        .i_ready       (queue_ready)
    );

    // The queue decouples the front end from the back end, so that a stall
    // at the output does not reach the input at once.
    pdcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (queue_ready),
        .i_ent   (front_ent),
        .o_valid (queue_valid),
        .o_ent   (queue_ent),
        .i_ready (back_ready)
    );

    // The back end forms the deltas, keeps the previous vertical difference
    // and holds the result register.
    pdcd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (queue_valid),
        .o_ready (back_ready),
        .i_ent   (queue_ent),
        .i_mode  (r_channel_mode),
        .o_valid (o_m_axis_tvalid),
        .o_res   (o_m_axis_tdata),
        .o_last  (o_m_axis_tlast),
        .i_ready (i_m_axis_tready)
    );

endmodule

### sv/pdcd_checker.sv
`include "assert_macros.svh"

module pdcd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);

    // Items accepted but not yet delivered: front stage, two queue
    // entries and the output register.
    localparam int CAP = 4;

    logic [2:0] r_inflight;
    logic       in_hs;
    logic       out_hs;

    assign in_hs  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_hs = o_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else if (in_hs && !out_hs) begin
            r_inflight <= r_inflight + 3'd1;
        end else if (out_hs && !in_hs) begin
            r_inflight <= r_inflight - 3'd1;
        end
    end

    `AST_HOLDS(a_out_hold, i_clk, i_rst_n, (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)), "stalled result changed")
    `AST_HOLDS(a_no_invented, i_clk, i_rst_n, out_hs |-> (r_inflight != 3'd0), "result without an accepted item")
    `AST_HOLDS(a_capacity, i_clk, i_rst_n, r_inflight <= 3'(CAP), "more items in flight than storage")
    `AST_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "result valid right after reset")

endmodule

bind pixel_delta_color_decorrelator pdcd_checker u_pdcd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
